[rtl/core/blg_pkg.sv]
// blg_pkg: shared types, widths, register indexes and reset values for the
// line pixel generator. No dependencies.
package blg_pkg;

  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned WinBits          = 12;
  localparam int unsigned LineBytesBits    = 16;
  localparam int unsigned BppBits          = 3;
  localparam int unsigned OffsetBits       = 27;
  localparam int unsigned ColorBits        = 24;
  localparam int unsigned CfgIndexBits     = 4;
  localparam int unsigned CfgDataBits      = 16;

  localparam logic [WinBits-1:0]       WinWidthReset  = 12'd1024;
  localparam logic [WinBits-1:0]       WinHeightReset = 12'd768;
  localparam logic [LineBytesBits-1:0] LineBytesReset = 16'd4096;
  localparam logic [BppBits-1:0]       BppReset       = 3'd4;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeStep = 1'b1;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_WINDOW_WIDTH    = 4'd0,
    CFG_WINDOW_HEIGHT   = 4'd1,
    CFG_LINE_BYTES      = 4'd2,
    CFG_BYTES_PER_PIXEL = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WinBits-1:0]       window_width;
    logic [WinBits-1:0]       window_height;
    logic [LineBytesBits-1:0] line_bytes;
    logic [BppBits-1:0]       bytes_per_pixel;
  } cfg_t;

  typedef struct packed {
    logic                  visible;
    logic [OffsetBits-1:0] byte_offset;
  } pix_info_t;

endpackage

[rtl/core/blg_pixel_addr.sv]
// blg_pixel_addr: window clipping and frame-buffer byte offset of one pixel.
// Depends on blg_pkg.
module blg_pixel_addr #(
  parameter int unsigned CoordBits = blg_pkg::CoordBitsDefault
) (
  input  blg_pkg::cfg_t                cfg_i,
  input  logic signed [CoordBits-1:0]  cur_x_i,
  input  logic signed [CoordBits-1:0]  cur_y_i,
  output blg_pkg::pix_info_t           info_o
);

  localparam int unsigned CmpW =
    (CoordBits > blg_pkg::WinBits) ? CoordBits : blg_pkg::WinBits;
  localparam int unsigned YProdW = CoordBits + blg_pkg::LineBytesBits;
  localparam int unsigned XProdW = CoordBits + blg_pkg::BppBits;

  logic              x_ok;
  logic              y_ok;
  logic [YProdW-1:0] y_prod;
  logic [XProdW-1:0] x_prod;

  assign x_ok = !cur_x_i[CoordBits-1] &&
                (CmpW'($unsigned(cur_x_i)) < CmpW'(cfg_i.window_width));
  assign y_ok = !cur_y_i[CoordBits-1] &&
                (CmpW'($unsigned(cur_y_i)) < CmpW'(cfg_i.window_height));

  assign y_prod = YProdW'($unsigned(cur_y_i)) * YProdW'(cfg_i.line_bytes);
  assign x_prod = XProdW'($unsigned(cur_x_i)) * XProdW'(cfg_i.bytes_per_pixel);

  assign info_o.visible     = x_ok && y_ok;
  assign info_o.byte_offset = (x_ok && y_ok)
                            ? blg_pkg::OffsetBits'(y_prod) + blg_pkg::OffsetBits'(x_prod)
                            : '0;

endmodule

[rtl/core/bresenham_line_pixel_generator.sv]
// Bresenham line pixel generator. Takes one word per clock when the result
// register is free or being drained; a step word gives its pixel through the
// input register, then the result register. The error update and the offset
// multiply are both combinational, computed while the step word sits in the input register.
// Load words and steps while idle produce no output and never wait on it.
// Depends on blg_pkg and blg_pixel_addr.
module bresenham_line_pixel_generator #(
  parameter int unsigned COORD_BITS = blg_pkg::CoordBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [blg_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [blg_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic signed [COORD_BITS-1:0]        x_start_i,
  input  logic signed [COORD_BITS-1:0]        y_start_i,
  input  logic signed [COORD_BITS-1:0]        x_end_i,
  input  logic signed [COORD_BITS-1:0]        y_end_i,
  input  logic [blg_pkg::ColorBits-1:0]       line_color_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_BITS-1:0]        pixel_x_o,
  output logic signed [COORD_BITS-1:0]        pixel_y_o,
  output logic [blg_pkg::OffsetBits-1:0]      byte_offset_o,
  output logic [blg_pkg::ColorBits-1:0]       pixel_color_o,
  output logic                                visible_o,
  output logic                                last_o
);

  localparam int unsigned ErrW = COORD_BITS + 2;
  localparam int unsigned E2W  = ErrW + 1;

  blg_pkg::cfg_t cfg_q;

  logic                          in_valid_q;
  logic                          mode_q;
  logic signed [COORD_BITS-1:0]  xs_q, ys_q, xe_q, ye_q;
  logic [blg_pkg::ColorBits-1:0] color_q;

  logic signed [COORD_BITS-1:0]  cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic signed [COORD_BITS-1:0]  cur_x_d, cur_y_d;
  logic [COORD_BITS-1:0]         delta_x_q, delta_y_q;
  logic                          step_x_neg_q, step_y_neg_q;
  logic signed [ErrW-1:0]        error_q, error_d;
  logic [blg_pkg::ColorBits-1:0] held_color_q;
  logic                          active_q;

  logic                          out_valid_q;
  logic signed [COORD_BITS-1:0]  pixel_x_q, pixel_y_q;
  logic [blg_pkg::OffsetBits-1:0] byte_offset_q;
  logic [blg_pkg::ColorBits-1:0] pixel_color_q;
  logic                          visible_q, last_q;

  logic                          is_load, produce, advance, is_last;
  logic signed [COORD_BITS:0]    dx_s, dy_s, dx_abs, dy_abs;
  logic [COORD_BITS-1:0]         dx_ld, dy_ld;
  logic signed [ErrW-1:0]        err_ld;
  logic signed [E2W-1:0]         e2, dx_w, dy_w, err_w;
  logic                          move_x, move_y;
  blg_pkg::pix_info_t            info;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_width    <= blg_pkg::WinWidthReset;
      cfg_q.window_height   <= blg_pkg::WinHeightReset;
      cfg_q.line_bytes      <= blg_pkg::LineBytesReset;
      cfg_q.bytes_per_pixel <= blg_pkg::BppReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        blg_pkg::CFG_WINDOW_WIDTH: begin
          cfg_q.window_width <= cfg_wdata_i[blg_pkg::WinBits-1:0];
        end
        blg_pkg::CFG_WINDOW_HEIGHT: begin
          cfg_q.window_height <= cfg_wdata_i[blg_pkg::WinBits-1:0];
        end
        blg_pkg::CFG_LINE_BYTES: begin
          cfg_q.line_bytes <= cfg_wdata_i[blg_pkg::LineBytesBits-1:0];
        end
        blg_pkg::CFG_BYTES_PER_PIXEL: begin
          cfg_q.bytes_per_pixel <= cfg_wdata_i[blg_pkg::BppBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // flow control
  assign is_load    = (mode_q == blg_pkg::ModeLoad);
  assign produce    = (mode_q == blg_pkg::ModeStep) && active_q;
  assign advance    = in_valid_q && (!produce || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q  <= mode_i;
      xs_q    <= x_start_i;
      ys_q    <= y_start_i;
      xe_q    <= x_end_i;
      ye_q    <= y_end_i;
      color_q <= line_color_i;
    end
  end

  // load setup
  assign dx_s   = (COORD_BITS + 1)'(xe_q) - (COORD_BITS + 1)'(xs_q);
  assign dy_s   = (COORD_BITS + 1)'(ye_q) - (COORD_BITS + 1)'(ys_q);
  assign dx_abs = dx_s[COORD_BITS] ? -dx_s : dx_s;
  assign dy_abs = dy_s[COORD_BITS] ? -dy_s : dy_s;
  assign dx_ld  = dx_abs[COORD_BITS-1:0];
  assign dy_ld  = dy_abs[COORD_BITS-1:0];
  assign err_ld = $signed(ErrW'(dx_ld)) - $signed(ErrW'(dy_ld));

  // error rule
  assign is_last = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
  assign e2      = {error_q, 1'b0};
  assign dx_w    = $signed(E2W'(delta_x_q));
  assign dy_w    = $signed(E2W'(delta_y_q));
  assign move_x  = e2 > -dy_w;
  assign move_y  = e2 < dx_w;
  assign err_w   = E2W'(error_q) - (move_x ? dy_w : '0) + (move_y ? dx_w : '0);
  assign error_d = err_w[ErrW-1:0];

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    if (move_x) begin
      cur_x_d = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
    end
    if (move_y) begin
      cur_y_d = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      delta_x_q    <= '0;
      delta_y_q    <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      error_q      <= '0;
      held_color_q <= '0;
    end else if (advance) begin
      if (is_load) begin
        active_q     <= 1'b1;
        cur_x_q      <= xs_q;
        cur_y_q      <= ys_q;
        end_x_q      <= xe_q;
        end_y_q      <= ye_q;
        delta_x_q    <= dx_ld;
        delta_y_q    <= dy_ld;
        step_x_neg_q <= !(xs_q < xe_q);
        step_y_neg_q <= !(ys_q < ye_q);
        error_q      <= err_ld;
        held_color_q <= color_q;
      end else if (produce) begin
        if (is_last) begin
          active_q <= 1'b0;
        end else begin
          cur_x_q <= cur_x_d;
          cur_y_q <= cur_y_d;
          error_q <= error_d;
        end
      end
    end
  end

  blg_pixel_addr #(
    .CoordBits (COORD_BITS)
  ) u_pixel_addr (
    .cfg_i   (cfg_q),
    .cur_x_i (cur_x_q),
    .cur_y_i (cur_y_q),
    .info_o  (info)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      pixel_x_q     <= cur_x_q;
      pixel_y_q     <= cur_y_q;
      byte_offset_q <= info.byte_offset;
      pixel_color_q <= held_color_q;
      visible_q     <= info.visible;
      last_q        <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign byte_offset_o = byte_offset_q;
  assign pixel_color_o = pixel_color_q;
  assign visible_o     = visible_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && produce && is_last |=> !active_q)
    else $error("generator still active after end point");

  a_load_starts_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_load |=> active_q)
    else $error("load word did not start a line");

  a_step_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && produce |=> out_valid_o)
    else $error("step word produced no output");

  a_hidden_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> byte_offset_o == '0)
    else $error("clipped pixel carries a byte offset");
`endif

endmodule

[bench/bresenham_line_pixel_generator_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for bresenham_line_pixel_generator: a directed table of lines, then
// random lines under several register settings, every pixel compared with the table or a line tracer.
// Depends on blg_pkg and the generator RTL.
module bresenham_line_pixel_generator_tb;

  localparam int CB          = blg_pkg::CoordBitsDefault;
  localparam int DrainCycles = 4;
  localparam int StallLimit  = 2000;
  localparam int PrintMax    = 100;

  typedef struct packed {
    logic                          mode;
    logic [CB-1:0]                 x0;
    logic [CB-1:0]                 y0;
    logic [CB-1:0]                 x1;
    logic [CB-1:0]                 y1;
    logic [blg_pkg::ColorBits-1:0] color;
  } word_t;

  typedef struct packed {
    logic [CB-1:0]                  x;
    logic [CB-1:0]                  y;
    logic [blg_pkg::OffsetBits-1:0] off;
    logic [blg_pkg::ColorBits-1:0]  color;
    logic                           vis;
    logic                           last;
  } pixel_t;

  typedef struct packed {
    word_t  w;
    logic   typed;
    logic   has;
    pixel_t want;
  } row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_valid;
  logic                             cfg_ready_o;
  blg_pkg::cfg_reg_e                cfg_index;
  logic [blg_pkg::CfgDataBits-1:0]  cfg_wdata;
  logic                             in_valid;
  logic                             in_ready_o;
  logic                             mode;
  logic [CB-1:0]                    x_start;
  logic [CB-1:0]                    y_start;
  logic [CB-1:0]                    x_end;
  logic [CB-1:0]                    y_end;
  logic [blg_pkg::ColorBits-1:0]    line_color;
  logic                             out_valid_o;
  logic                             out_ready;
  logic signed [CB-1:0]             pixel_x_o;
  logic signed [CB-1:0]             pixel_y_o;
  logic [blg_pkg::OffsetBits-1:0]   byte_offset_o;
  logic [blg_pkg::ColorBits-1:0]    pixel_color_o;
  logic                             visible_o;
  logic                             last_o;

  // line tracer state
  blg_pkg::cfg_t                    cfg_model;
  logic [CB-1:0]                    trace_x, trace_y, goal_x, goal_y;
  logic [CB-1:0]                    run_dx, run_dy;
  logic                             x_neg, y_neg;
  logic [13:0]                      err_acc;
  logic [blg_pkg::ColorBits-1:0]    held_color;
  logic                             drawing;

  pixel_t pixel_q[$];
  int     errors      = 0;
  int     words_used  = 0;
  int     stall_len   = 0;
  int     idle_cycles = 0;
  bit     in_gaps     = 1'b1;
  bit     out_gaps    = 1'b1;

  bresenham_line_pixel_generator #(
    .COORD_BITS(CB)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode),
    .x_start_i    (x_start),
    .y_start_i    (y_start),
    .x_end_i      (x_end),
    .y_end_i      (y_end),
    .line_color_i (line_color),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .byte_offset_o(byte_offset_o),
    .pixel_color_o(pixel_color_o),
    .visible_o    (visible_o),
    .last_o       (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // advances the tracer by one accepted word, returns 1 when a pixel comes out
  function automatic bit rasterize(input word_t w, output pixel_t p);
    int     x0, y0, x1, y1, ddx, ddy, cx, cy, dxi, dyi, e2, ev;
    longint ofs;
    bit     vis, fin;
    p = '0;
    if (w.mode == blg_pkg::ModeLoad) begin
      x0 = $signed(w.x0);
      y0 = $signed(w.y0);
      x1 = $signed(w.x1);
      y1 = $signed(w.y1);
      ddx = x1 - x0;
      ddy = y1 - y0;
      if (ddx < 0) ddx = -ddx;
      if (ddy < 0) ddy = -ddy;
      trace_x = w.x0;
      trace_y = w.y0;
      goal_x = w.x1;
      goal_y = w.y1;
      run_dx = ddx[CB-1:0];
      run_dy = ddy[CB-1:0];
      x_neg = !(x0 < x1);
      y_neg = !(y0 < y1);
      ev = int'(run_dx) - int'(run_dy);
      err_acc = ev[13:0];
      held_color = w.color;
      drawing = 1'b1;
      return 1'b0;
    end
    if (!drawing) return 1'b0;
    cx = $signed(trace_x);
    cy = $signed(trace_y);
    vis = cx >= 0 && cy >= 0 && cx < int'(cfg_model.window_width) &&
          cy < int'(cfg_model.window_height);
    ofs = 0;
    if (vis) begin
      ofs = longint'(cy) * longint'(cfg_model.line_bytes) +
            longint'(cx) * longint'(cfg_model.bytes_per_pixel);
    end
    fin = (trace_x == goal_x) && (trace_y == goal_y);
    p.x = trace_x;
    p.y = trace_y;
    p.off = ofs[blg_pkg::OffsetBits-1:0];
    p.color = held_color;
    p.vis = vis;
    p.last = fin;
    if (fin) begin
      drawing = 1'b0;
      return 1'b1;
    end
    dxi = int'(run_dx);
    dyi = int'(run_dy);
    ev = $signed(err_acc);
    e2 = 2 * ev;
    if (e2 > -dyi) begin
      ev = ev - dyi;
      cx = x_neg ? cx - 1 : cx + 1;
    end
    if (e2 < dxi) begin
      ev = ev + dxi;
      cy = y_neg ? cy - 1 : cy + 1;
    end
    trace_x = cx[CB-1:0];
    trace_y = cy[CB-1:0];
    err_acc = ev[13:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want_v);
    if (errors < PrintMax) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want_v);
    end
    errors++;
  endtask

  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel, x", $unsigned(pixel_x_o), 0);
      end else begin
        want = pixel_q.pop_front();
        if (pixel_x_o !== want.x) report_mismatch("pixel_x", $unsigned(pixel_x_o), want.x);
        if (pixel_y_o !== want.y) report_mismatch("pixel_y", $unsigned(pixel_y_o), want.y);
        if (byte_offset_o !== want.off) report_mismatch("byte_offset", byte_offset_o, want.off);
        if (pixel_color_o !== want.color) begin
          report_mismatch("pixel_color", pixel_color_o, want.color);
        end
        if (visible_o !== want.vis) report_mismatch("visible", visible_o, want.vis);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // pixel sink
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        stall_len--;
      end else begin
        out_ready <= !(out_gaps && $urandom_range(99) < 9);
      end
    end
  end

  task automatic send_word(input row_t r);
    pixel_t p;
    bit     got;
    @(negedge clk_i);
    while (in_gaps && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    mode <= r.w.mode;
    x_start <= r.w.x0;
    y_start <= r.w.y0;
    x_end <= r.w.x1;
    y_end <= r.w.y1;
    line_color <= r.w.color;
    do @(posedge clk_i); while (!in_ready_o);
    got = rasterize(r.w, p);
    if (got || r.w.mode == blg_pkg::ModeLoad) words_used++;
    if (r.typed) begin
      got = r.has;
      p = r.want;
    end
    if (got) pixel_q.push_back(p);
  endtask

  task automatic drain_pixels();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input blg_pkg::cfg_reg_e idx, input int v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[blg_pkg::CfgDataBits-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      blg_pkg::CFG_WINDOW_WIDTH:    cfg_model.window_width = v[blg_pkg::WinBits-1:0];
      blg_pkg::CFG_WINDOW_HEIGHT:   cfg_model.window_height = v[blg_pkg::WinBits-1:0];
      blg_pkg::CFG_LINE_BYTES:      cfg_model.line_bytes = v[blg_pkg::LineBytesBits-1:0];
      blg_pkg::CFG_BYTES_PER_PIXEL: cfg_model.bytes_per_pixel = v[blg_pkg::BppBits-1:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input int ww, input int wh, input int lb, input int bpp);
    write_reg(blg_pkg::CFG_WINDOW_WIDTH, ww);
    write_reg(blg_pkg::CFG_WINDOW_HEIGHT, wh);
    write_reg(blg_pkg::CFG_LINE_BYTES, lb);
    write_reg(blg_pkg::CFG_BYTES_PER_PIXEL, bpp);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // one load word, then its steps; some lines are cut short or overrun
  task automatic send_line(input int lo, input int span, input bit whole);
    row_t r;
    int   x0, y0, x1, y1, ox, oy, hi, n;
    r = '0;
    if ($urandom_range(9) < 7) begin
      hi = int'(cfg_model.window_width) + 4;
      if (hi > 2047) hi = 2047;
      x0 = int'($urandom_range(0, hi + 4)) - 4;
      hi = int'(cfg_model.window_height) + 4;
      if (hi > 2047) hi = 2047;
      y0 = int'($urandom_range(0, hi + 4)) - 4;
    end else begin
      x0 = int'($urandom_range(0, 4095)) - 2048;
      y0 = int'($urandom_range(0, 4095)) - 2048;
    end
    ox = $urandom_range(lo, span);
    oy = $urandom_range(lo, span);
    if ($urandom_range(1)) ox = -ox;
    if ($urandom_range(1)) oy = -oy;
    x1 = x0 + ox;
    y1 = y0 + oy;
    if (x1 > 2047 || x1 < -2048) x1 = x0 - ox;
    if (y1 > 2047 || y1 < -2048) y1 = y0 - oy;
    r.w.mode = blg_pkg::ModeLoad;
    r.w.x0 = x0[CB-1:0];
    r.w.y0 = y0[CB-1:0];
    r.w.x1 = x1[CB-1:0];
    r.w.y1 = y1[CB-1:0];
    r.w.color = $urandom;
    send_word(r);
    if (ox < 0) ox = -ox;
    if (oy < 0) oy = -oy;
    n = ((ox > oy) ? ox : oy) + 1;
    if (!whole) begin
      case ($urandom_range(9))
        0: n = $urandom_range(0, n - 1);
        1: n = n + $urandom_range(1, 3);
        default: ;
      endcase
    end
    repeat (n) begin
      r.w.mode = blg_pkg::ModeStep;
      r.w.x0 = $urandom;
      r.w.y0 = $urandom;
      r.w.x1 = $urandom;
      r.w.y1 = $urandom;
      r.w.color = $urandom;
      send_word(r);
    end
  endtask

  task automatic run_lines(input int quota);
    int stop_at;
    stop_at = words_used + quota;
    while (words_used < stop_at) begin
      if ($urandom_range(19) == 0) send_line(0, 200, 1'b0);
      else send_line(0, 12, 1'b0);
    end
  endtask

  function automatic row_t load_row(input int x0, input int y0, input int x1, input int y1,
                                    input logic [blg_pkg::ColorBits-1:0] col);
    row_t r;
    r = '0;
    r.w.mode = blg_pkg::ModeLoad;
    r.w.x0 = x0[CB-1:0];
    r.w.y0 = y0[CB-1:0];
    r.w.x1 = x1[CB-1:0];
    r.w.y1 = y1[CB-1:0];
    r.w.color = col;
    return r;
  endfunction

  function automatic row_t step_row(input bit typed, input bit has, input pixel_t want);
    row_t r;
    r = '0;
    r.w.mode = blg_pkg::ModeStep;
    r.typed = typed;
    r.has = has;
    r.want = want;
    return r;
  endfunction

  function automatic pixel_t pix(input int x, input int y, input longint off,
                                 input logic [blg_pkg::ColorBits-1:0] col, input bit vis,
                                 input bit last);
    pixel_t p;
    p.x = x[CB-1:0];
    p.y = y[CB-1:0];
    p.off = off[blg_pkg::OffsetBits-1:0];
    p.color = col;
    p.vis = vis;
    p.last = last;
    return p;
  endfunction

  initial begin : stimulus
    row_t dir_rows[$];
    rst_ni <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= blg_pkg::CFG_WINDOW_WIDTH;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    mode <= blg_pkg::ModeLoad;
    x_start <= '0;
    y_start <= '0;
    x_end <= '0;
    y_end <= '0;
    line_color <= '0;
    cfg_model.window_width = blg_pkg::WinWidthReset;
    cfg_model.window_height = blg_pkg::WinHeightReset;
    cfg_model.line_bytes = blg_pkg::LineBytesReset;
    cfg_model.bytes_per_pixel = blg_pkg::BppReset;
    trace_x = '0;
    trace_y = '0;
    goal_x = '0;
    goal_y = '0;
    run_dx = '0;
    run_dy = '0;
    x_neg = 1'b0;
    y_neg = 1'b0;
    err_acc = '0;
    held_color = '0;
    drawing = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // step while idle after reset
    dir_rows.push_back(step_row(1'b1, 1'b0, '0));
    // single point
    dir_rows.push_back(load_row(0, 0, 0, 0, 24'hFFFFFF));
    dir_rows.push_back(step_row(1'b1, 1'b1, pix(0, 0, 0, 24'hFFFFFF, 1'b1, 1'b1)));
    // corner to corner, then restarted mid line in the other direction
    dir_rows.push_back(load_row(-2048, -2048, 2047, 2047, 24'h000000));
    dir_rows.push_back(step_row(1'b1, 1'b1, pix(-2048, -2048, 0, 24'h000000, 1'b0, 1'b0)));
    dir_rows.push_back(step_row(1'b0, 1'b0, '0));
    dir_rows.push_back(load_row(2047, 2047, -2048, -2048, 24'hAAAAAA));
    dir_rows.push_back(step_row(1'b1, 1'b1, pix(2047, 2047, 0, 24'hAAAAAA, 1'b0, 1'b0)));
    dir_rows.push_back(step_row(1'b0, 1'b0, '0));
    // last visible pixel of the default window, and the first one past it
    dir_rows.push_back(load_row(1023, 767, 1023, 767, 24'h555555));
    dir_rows.push_back(step_row(1'b1, 1'b1,
                                pix(1023, 767, 767 * 4096 + 1023 * 4, 24'h555555, 1'b1, 1'b1)));
    dir_rows.push_back(load_row(1024, 0, 1024, 0, 24'h0F0F0F));
    dir_rows.push_back(step_row(1'b1, 1'b1, pix(1024, 0, 0, 24'h0F0F0F, 1'b0, 1'b1)));
    // both steps negative
    dir_rows.push_back(load_row(5, 3, 0, 0, 24'h123456));
    repeat (6) dir_rows.push_back(step_row(1'b0, 1'b0, '0));
    // vertical, no move on x, then one step past the end
    dir_rows.push_back(load_row(0, 0, 0, -3, 24'h654321));
    repeat (5) dir_rows.push_back(step_row(1'b0, 1'b0, '0));
    foreach (dir_rows[i]) send_word(dir_rows[i]);

    run_lines(150);
    drain_pixels();

    in_gaps = 1'b0;
    out_gaps = 1'b0;
    write_regs(640, 480, 1280, 2);
    run_lines(120);
    drain_pixels();

    in_gaps = 1'b1;
    out_gaps = 1'b1;
    write_regs(1, 1, 0, 1);
    run_lines(80);
    drain_pixels();

    write_regs(2048, 2048, 65535, 4);
    run_lines(60);
    // sink holds off while a long line keeps coming
    stall_len = 300;
    send_line(60, 60, 1'b1);
    run_lines(60);
    drain_pixels();

    write_regs(0, 4095, 65535, 7);
    run_lines(60);
    drain_pixels();

    write_regs(4095, 0, 1, 0);
    run_lines(60);
    drain_pixels();

    write_regs($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535),
               $urandom_range(0, 7));
    run_lines(60);
    drain_pixels();

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
